@@ hw/rtl/pcsdf_pkg.sv @@
// Shared types and constants for the per-code severity debounce filter.
// No dependencies; imported by every module of the block but pcsdf_checker.
`default_nettype none

package pcsdf_pkg;

  localparam int NUM_CODES = 256;
  localparam int CODE_AW   = (NUM_CODES > 1) ? $clog2(NUM_CODES) : 1;

  localparam logic [7:0] SEV_NEVER      = 8'hFF;
  localparam logic [1:0] CONFIRM_NEEDED = 2'd2;

  typedef enum logic {
    OP_REPORT  = 1'b0,
    OP_FORWARD = 1'b1
  } op_t;

  // One table entry per code.
  typedef struct packed {
    logic [7:0] committed;
    logic [7:0] candidate;
    logic [1:0] count;
    logic       pending;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    committed: SEV_NEVER,
    candidate: SEV_NEVER,
    count:     2'd0,
    pending:   1'b0
  };

  // Side effects of one transaction besides the entry write-back.
  typedef struct packed {
    logic emit;
    logic qdrop;
    logic fdrop;
  } upd_flags_t;

endpackage

`default_nettype wire

@@ hw/rtl/pcsdf_table.sv @@
// Per-code entry memory: one synchronous RAM, registered read, plus valid bits.
// Depends on pcsdf_pkg (entry_t, ENTRY_RESET, NUM_CODES, CODE_AW).
`default_nettype none

module pcsdf_table
  import pcsdf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               rd_en,
  input  wire logic [CODE_AW-1:0] rd_addr,
  output entry_t                  rd_entry,
  input  wire logic               wr_en,
  input  wire logic [CODE_AW-1:0] wr_addr,
  input  wire entry_t             wr_entry
);

  entry_t               mem_r [NUM_CODES];
  logic [NUM_CODES-1:0] vld_r;
  entry_t               rd_q_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  // Valid bits stand in for the reset contents of the RAM.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_entry = rd_vld_r ? rd_q_r : ENTRY_RESET;

endmodule

`default_nettype wire

@@ hw/rtl/pcsdf_update.sv @@
// Entry update: debounce, dedup and drop decisions for one transaction.
// Depends on pcsdf_pkg (entry_t, upd_flags_t, op_t, constants).
`default_nettype none

module pcsdf_update
  import pcsdf_pkg::*;
(
  input  wire entry_t      entry_i,
  input  wire op_t         op_i,
  input  wire logic [7:0]  sev_i,
  input  wire logic        qfull_i,
  input  wire logic        fok_i,
  output entry_t           entry_o,
  output upd_flags_t       flags_o
);

  logic confirmed;

  always_comb begin
    entry_o   = entry_i;
    flags_o   = '0;
    confirmed = 1'b0;
    case (op_i)
      OP_REPORT: begin
        if (entry_i.committed == sev_i) begin
          // same as committed: drop candidate
          entry_o.candidate = SEV_NEVER;
          entry_o.count     = 2'd0;
        end else begin
          if (entry_i.candidate != sev_i) begin
            entry_o.candidate = sev_i;
            if (entry_i.committed == SEV_NEVER) begin
              // first report for the code passes at once
              entry_o.count = CONFIRM_NEEDED;
              confirmed     = 1'b1;
            end else begin
              entry_o.count = 2'd1;
            end
          end else begin
            if (entry_i.count < CONFIRM_NEEDED) begin
              entry_o.count = entry_i.count + 2'd1;
            end
            confirmed = (entry_o.count >= CONFIRM_NEEDED);
          end
          if (confirmed && !entry_i.pending) begin
            if (qfull_i) begin
              entry_o.pending = 1'b0;
              flags_o.qdrop   = 1'b1;
            end else begin
              entry_o.pending = 1'b1;
              flags_o.emit    = 1'b1;
            end
          end
        end
      end
      OP_FORWARD: begin
        if (fok_i) begin
          entry_o.committed = sev_i;
        end else begin
          flags_o.fdrop = 1'b1;
        end
        entry_o.pending = 1'b0;
      end
      default: begin
        entry_o = entry_i;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/per_code_severity_debounce_filter_top.sv @@
// Top level of the per-code severity debounce filter.
// Depends on pcsdf_pkg, pcsdf_table and pcsdf_update.
//
// Usage:
//   Input channel (in_valid/in_ready): one transaction is a report
//   (in_operation = 0) or a forward result (in_operation = 1) for in_code.
//   Output channel (out_valid/out_ready): exactly one result transaction per
//   input transaction, in order. out_emit flags an entry passed to the queue;
//   the entry fields read zero when out_emit is low. out_queue_drops and
//   out_forward_drops carry the drop counters after the transaction.
// Timing:
//   Each transaction reads its code's entry from the table RAM (registered
//   read), then in its update cycle updates and writes it back while the
//   result is loaded into the output register. A new transaction is taken
//   only after the write-back of the previous one, since the RAM read is
//   followed by the write-back of the same entry.
//   in_ready is low only during the update cycle, so a new transaction is
//   taken while an earlier result still waits in the output register.
// Stall:
//   If the receiver holds out_ready low with a result waiting, the next
//   transaction parks in its update cycle until the output register frees.
// Reset:
//   rst_n (synchronous, active low) clears the RAM valid bits, so every code
//   reads as never logged, and clears both drop counters. No clearing pass.
`default_nettype none

module per_code_severity_debounce_filter_top
  import pcsdf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_operation,
  input  wire logic [7:0]  in_code,
  input  wire logic [7:0]  in_severity,
  input  wire logic [31:0] in_aux_data,
  input  wire logic [31:0] in_tick_time,
  input  wire logic        in_log_queue_full,
  input  wire logic        in_forward_ok,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_emit,
  output logic [7:0]       out_code,
  output logic [7:0]       out_severity,
  output logic [31:0]      out_timestamp,
  output logic [31:0]      out_aux,
  output logic [31:0]      out_queue_drops,
  output logic [31:0]      out_forward_drops
);

  // ---- control ----
  logic busy_r, busy_nxt;       // transaction in its update cycle
  logic out_valid_r, out_valid_nxt;
  logic accept;
  logic done;                   // update cycle completes this edge
  logic in_range;

  // ---- captured transaction (payload, no reset) ----
  op_t         op_r;
  logic [7:0]  code_r;
  logic [7:0]  sev_r;
  logic [31:0] aux_r;
  logic [31:0] tick_r;
  logic        qfull_r;
  logic        fok_r;
  logic        in_range_r;

  // ---- counters ----
  logic [31:0] qdrops_r, qdrops_nxt;
  logic [31:0] fdrops_r, fdrops_nxt;

  // ---- output register payload ----
  logic        emit_r;
  logic [7:0]  ocode_r;
  logic [7:0]  osev_r;
  logic [31:0] ots_r;
  logic [31:0] oaux_r;
  logic [31:0] oqd_r;
  logic [31:0] ofd_r;

  // ---- table and update ----
  entry_t     rd_entry;
  entry_t     upd_entry;
  upd_flags_t upd_flags;
  upd_flags_t flags;            // gated by code range
  logic       wr_en;

  assign in_range = ({1'b0, in_code} < 9'(NUM_CODES));
  assign in_ready = !busy_r;
  assign accept   = in_valid && in_ready;
  // busy blocks new reads until the write-back lands: no same-entry overlap
  assign done     = busy_r && (!out_valid_r || out_ready);
  assign wr_en    = done && in_range_r;
  assign flags    = in_range_r ? upd_flags : '0;

  pcsdf_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept && in_range),
    .rd_addr  (in_code[CODE_AW-1:0]),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (code_r[CODE_AW-1:0]),
    .wr_entry (upd_entry)
  );

  pcsdf_update u_update (
    .entry_i (rd_entry),
    .op_i    (op_r),
    .sev_i   (sev_r),
    .qfull_i (qfull_r),
    .fok_i   (fok_r),
    .entry_o (upd_entry),
    .flags_o (upd_flags)
  );

  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    qdrops_nxt    = qdrops_r;
    fdrops_nxt    = fdrops_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (done) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      qdrops_nxt    = qdrops_r + 32'(flags.qdrop);
      fdrops_nxt    = fdrops_r + 32'(flags.fdrop);
    end
    if (accept) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      qdrops_r    <= '0;
      fdrops_r    <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      qdrops_r    <= qdrops_nxt;
      fdrops_r    <= fdrops_nxt;
    end
  end

  // capture transaction on acceptance
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= op_t'(in_operation);
      code_r     <= in_code;
      sev_r      <= in_severity;
      aux_r      <= in_aux_data;
      tick_r     <= in_tick_time;
      qfull_r    <= in_log_queue_full;
      fok_r      <= in_forward_ok;
      in_range_r <= in_range;
    end
  end

  // load result; entry fields zero unless emitted
  always_ff @(posedge clk) begin
    if (done) begin
      emit_r  <= flags.emit;
      ocode_r <= flags.emit ? code_r : 8'd0;
      osev_r  <= flags.emit ? sev_r  : 8'd0;
      ots_r   <= flags.emit ? tick_r : 32'd0;
      oaux_r  <= flags.emit ? aux_r  : 32'd0;
      oqd_r   <= qdrops_nxt;
      ofd_r   <= fdrops_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_emit          = emit_r;
  assign out_code          = ocode_r;
  assign out_severity      = osev_r;
  assign out_timestamp     = ots_r;
  assign out_aux           = oaux_r;
  assign out_queue_drops   = oqd_r;
  assign out_forward_drops = ofd_r;

endmodule

`default_nettype wire

@@ hw/rtl/pcsdf_checker.sv @@
// Port-level checker for the debounce filter top, attached by bind.
// Depends on per_code_severity_debounce_filter_top's port list.
`default_nettype none

module pcsdf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_operation,
  input wire logic [7:0]  in_code,
  input wire logic [7:0]  in_severity,
  input wire logic [31:0] in_aux_data,
  input wire logic [31:0] in_tick_time,
  input wire logic        in_log_queue_full,
  input wire logic        in_forward_ok,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_emit,
  input wire logic [7:0]  out_code,
  input wire logic [7:0]  out_severity,
  input wire logic [31:0] out_timestamp,
  input wire logic [31:0] out_aux,
  input wire logic [31:0] out_queue_drops,
  input wire logic [31:0] out_forward_drops
);

  // one transaction in the update cycle at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high in cycle after acceptance");

  // with the output register free, the result follows with no stall
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !out_valid) |-> ##2 out_valid)
    else $error("result missing two cycles after acceptance");

  // entry fields are zero when nothing was emitted
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_emit) |->
      (out_code == 8'd0) && (out_severity == 8'd0) &&
      (out_timestamp == 32'd0) && (out_aux == 32'd0))
    else $error("entry fields nonzero without emit");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      out_valid && $stable(out_emit) && $stable(out_queue_drops) &&
      $stable(out_forward_drops) && $stable(out_code))
    else $error("stalled result changed");

  // waiting input transaction holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |=>
      in_valid && $stable(in_operation) && $stable(in_code) &&
      $stable(in_severity) && $stable(in_aux_data) && $stable(in_tick_time) &&
      $stable(in_log_queue_full) && $stable(in_forward_ok))
    else $error("waiting input transaction changed");

endmodule

bind per_code_severity_debounce_filter_top pcsdf_checker u_pcsdf_checker (.*);

`default_nettype wire

@@ tb/debounce_filter_checker.sv @@
// Checker for the per-code severity debounce filter: watches both channels,
// predicts each result from its own copy of the code tables and compares.
// Depends on pcsdf_pkg for the operation codes and table constants.
`timescale 1ns / 1ps

module debounce_filter_checker
  import pcsdf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        in_operation,
  input  wire logic [7:0]  in_code,
  input  wire logic [7:0]  in_severity,
  input  wire logic [31:0] in_aux_data,
  input  wire logic [31:0] in_tick_time,
  input  wire logic        in_log_queue_full,
  input  wire logic        in_forward_ok,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic        out_emit,
  input  wire logic [7:0]  out_code,
  input  wire logic [7:0]  out_severity,
  input  wire logic [31:0] out_timestamp,
  input  wire logic [31:0] out_aux,
  input  wire logic [31:0] out_queue_drops,
  input  wire logic [31:0] out_forward_drops,
  output int               errors,
  output int               outstanding
);

  typedef struct packed {
    logic        emit;
    logic [7:0]  code;
    logic [7:0]  severity;
    logic [31:0] timestamp;
    logic [31:0] aux;
    logic [31:0] queue_drops;
    logic [31:0] forward_drops;
  } filter_result_t;

  logic [7:0]  committed_sev [NUM_CODES];
  logic [7:0]  candidate_sev [NUM_CODES];
  logic [1:0]  confirm_cnt   [NUM_CODES];
  logic        pending       [NUM_CODES];
  logic [31:0] queue_drop_cnt;
  logic [31:0] forward_drop_cnt;

  filter_result_t expected_entries [$];

  function automatic filter_result_t filter_event(op_t op, logic [7:0] code, logic [7:0] sev,
                                                  logic [31:0] aux, logic [31:0] tick,
                                                  logic qfull, logic fok);
    filter_result_t r;
    logic           confirmed;
    r = '0;
    confirmed = 1'b1;
    if (int'(code) < NUM_CODES) begin
      if (op == OP_REPORT) begin
        if (committed_sev[code] == sev) begin
          // back to the committed level: drop any candidate
          candidate_sev[code] = SEV_NEVER;
          confirm_cnt[code] = 2'd0;
        end else begin
          if (candidate_sev[code] != sev) begin
            candidate_sev[code] = sev;
            if (committed_sev[code] == SEV_NEVER) begin
              confirm_cnt[code] = CONFIRM_NEEDED;
            end else begin
              confirm_cnt[code] = 2'd1;
              confirmed = 1'b0;
            end
          end else if (confirm_cnt[code] < CONFIRM_NEEDED) begin
            confirm_cnt[code] = confirm_cnt[code] + 2'd1;
          end
          if (confirmed && confirm_cnt[code] >= CONFIRM_NEEDED && !pending[code]) begin
            if (qfull) begin
              queue_drop_cnt = queue_drop_cnt + 32'd1;
            end else begin
              pending[code] = 1'b1;
              r.emit = 1'b1;
              r.code = code;
              r.severity = sev;
              r.timestamp = tick;
              r.aux = aux;
            end
          end
        end
      end else begin
        if (fok) committed_sev[code] = sev;
        else forward_drop_cnt = forward_drop_cnt + 32'd1;
        pending[code] = 1'b0;
      end
    end
    r.queue_drops = queue_drop_cnt;
    r.forward_drops = forward_drop_cnt;
    return r;
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    filter_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_CODES; i++) begin
        committed_sev[i] = SEV_NEVER;
        candidate_sev[i] = SEV_NEVER;
        confirm_cnt[i] = 2'd0;
        pending[i] = 1'b0;
      end
      queue_drop_cnt = '0;
      forward_drop_cnt = '0;
      expected_entries.delete();
      errors = 0;
    end else begin
      // results first: a result never belongs to a transaction taken at the same edge
      if (out_valid && out_ready) begin
        if (expected_entries.size() == 0) begin
          errors++;
          $display("%0t: result with no transaction outstanding, expected none, got code 0x%0h",
                   $time, out_code);
        end else begin
          want = expected_entries.pop_front();
          check_field("emit", 32'(want.emit), 32'(out_emit));
          check_field("code", 32'(want.code), 32'(out_code));
          check_field("severity", 32'(want.severity), 32'(out_severity));
          check_field("timestamp", want.timestamp, out_timestamp);
          check_field("aux", want.aux, out_aux);
          check_field("queue_drops", want.queue_drops, out_queue_drops);
          check_field("forward_drops", want.forward_drops, out_forward_drops);
        end
      end
      if (in_valid && in_ready) begin
        expected_entries.push_back(filter_event(op_t'(in_operation), in_code, in_severity,
                                                in_aux_data, in_tick_time,
                                                in_log_queue_full, in_forward_ok));
      end
    end
    outstanding = expected_entries.size();
  end

endmodule

@@ tb/per_code_severity_debounce_filter_top_test.sv @@
// Testbench top for the per-code severity debounce filter: drives directed and
// random transactions under several idle patterns and gives the verdict.
// Depends on pcsdf_pkg, the filter RTL and debounce_filter_checker.
`timescale 1ns / 1ps

module per_code_severity_debounce_filter_top_test;
  import pcsdf_pkg::*;

  // Generous bound on the whole run.
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 8;
  localparam int PHASE_ITEMS = 450;   // random transactions per idle phase

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_operation = OP_REPORT;
  logic [7:0]  in_code = '0;
  logic [7:0]  in_severity = '0;
  logic [31:0] in_aux_data = '0;
  logic [31:0] in_tick_time = '0;
  logic        in_log_queue_full = 1'b0;
  logic        in_forward_ok = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_emit;
  logic [7:0]  out_code;
  logic [7:0]  out_severity;
  logic [31:0] out_timestamp;
  logic [31:0] out_aux;
  logic [31:0] out_queue_drops;
  logic [31:0] out_forward_drops;

  int errors;
  int outstanding;
  int cycle_count = 0;

  // Idle percentages of the current phase, read by the driver and the receiver.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  per_code_severity_debounce_filter_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_code          (in_code),
    .in_severity      (in_severity),
    .in_aux_data      (in_aux_data),
    .in_tick_time     (in_tick_time),
    .in_log_queue_full(in_log_queue_full),
    .in_forward_ok    (in_forward_ok),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_emit         (out_emit),
    .out_code         (out_code),
    .out_severity     (out_severity),
    .out_timestamp    (out_timestamp),
    .out_aux          (out_aux),
    .out_queue_drops  (out_queue_drops),
    .out_forward_drops(out_forward_drops)
  );

  debounce_filter_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_code          (in_code),
    .in_severity      (in_severity),
    .in_aux_data      (in_aux_data),
    .in_tick_time     (in_tick_time),
    .in_log_queue_full(in_log_queue_full),
    .in_forward_ok    (in_forward_ok),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_emit         (out_emit),
    .out_code         (out_code),
    .out_severity     (out_severity),
    .out_timestamp    (out_timestamp),
    .out_aux          (out_aux),
    .out_queue_drops  (out_queue_drops),
    .out_forward_drops(out_forward_drops),
    .errors           (errors),
    .outstanding      (outstanding)
  );

  // Receiver: ready drawn fresh every cycle from the phase's stall rate.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // One transaction on the input channel. Called at a rising edge; returns at
  // the edge that accepted it, with valid still high so back-to-back
  // transactions never drop valid in between. in_ready is sampled at the
  // falling edge, where it is settled, to decide whether the next edge takes it.
  task automatic send_txn(op_t op, logic [7:0] code, logic [7:0] sev, logic [31:0] aux,
                          logic [31:0] tick, logic qfull, logic fok);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_code <= code;
    in_severity <= sev;
    in_aux_data <= aux;
    in_tick_time <= tick;
    in_log_queue_full <= qfull;
    in_forward_ok <= fok;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // Mostly a handful of codes so that tables see repeated traffic; sometimes
  // any code, so every code bit toggles.
  function automatic logic [7:0] pick_code();
    if ($urandom_range(3) != 0) return 8'($urandom_range(5));
    return 8'($urandom_range(255));
  endfunction

  // Mostly a few levels (never-logged included) so severities repeat.
  function automatic logic [7:0] pick_sev();
    case ($urandom_range(9))
      0, 1:    return 8'h00;
      2, 3:    return 8'h01;
      4:       return 8'h02;
      5, 6:    return SEV_NEVER;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Random traffic: mostly debounce sequences (report, often a repeat, then
  // the forward result), the rest single transactions with all fields but the code fully random.
  task automatic random_traffic(int count);
    int         sent;
    logic [7:0] c;
    logic [7:0] s;
    sent = 0;
    while (sent < count) begin
      c = pick_code();
      s = pick_sev();
      if ($urandom_range(99) < 70) begin
        send_txn(OP_REPORT, c, s, $urandom, $urandom, ($urandom_range(9) == 0), 1'($urandom));
        sent++;
        if ($urandom_range(3) != 0) begin
          send_txn(OP_REPORT, c, s, $urandom, $urandom, ($urandom_range(9) == 0),
                   1'($urandom));
          sent++;
        end
        if ($urandom_range(5) != 0) begin
          // forward result, usually for the severity just reported
          send_txn(OP_FORWARD, c, ($urandom_range(4) == 0) ? pick_sev() : s,
                   $urandom, $urandom, 1'($urandom), ($urandom_range(5) != 0));
          sent++;
        end
      end else begin
        send_txn(op_t'($urandom_range(1)), c, 8'($urandom_range(255)), $urandom, $urandom,
                 1'($urandom), 1'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, no idling.
    // First report of a never-logged code passes at once.
    send_txn(OP_REPORT, 8'd0, 8'h00, 32'h0, 32'h0, 1'b0, 1'b1);
    // Same report again while pending: deduplicated.
    send_txn(OP_REPORT, 8'd0, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
    // Successful forward commits; unused report fields set to garbage.
    send_txn(OP_FORWARD, 8'd0, 8'h00, 32'hDEAD_BEEF, 32'h1234_5678, 1'b1, 1'b1);
    // Report at the committed level is ignored.
    send_txn(OP_REPORT, 8'd0, 8'h00, 32'h1, 32'h2, 1'b0, 1'b0);
    // Changed severity needs two reports in a row.
    send_txn(OP_REPORT, 8'd0, 8'h05, 32'h3, 32'h4, 1'b0, 1'b0);
    send_txn(OP_REPORT, 8'd0, 8'h05, 32'h5, 32'h6, 1'b0, 1'b0);
    // Forward dropped downstream: counted, pending cleared.
    send_txn(OP_FORWARD, 8'd0, 8'h05, 32'h0, 32'h0, 1'b0, 1'b0);
    // Count already saturated: a third report passes again.
    send_txn(OP_REPORT, 8'd0, 8'h05, 32'h7, 32'h8, 1'b0, 1'b0);
    send_txn(OP_REPORT, 8'd0, 8'h05, 32'h9, 32'hA, 1'b0, 1'b0);
    // Never-logged severity on a never-logged code is ignored.
    send_txn(OP_REPORT, 8'd255, SEV_NEVER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
    // Full queue: pass is lost and counted, twice.
    send_txn(OP_REPORT, 8'd255, 8'h80, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_txn(OP_REPORT, 8'd255, 8'h80, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_txn(OP_REPORT, 8'd255, 8'h80, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
    // Committing the never-logged value resets the code to never logged.
    send_txn(OP_FORWARD, 8'd255, SEV_NEVER, 32'h0, 32'h0, 1'b0, 1'b1);
    send_txn(OP_REPORT, 8'd255, 8'h12, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, 1'b0);
    // Forward results for a code that is not pending.
    send_txn(OP_FORWARD, 8'd7, 8'h03, 32'h0, 32'h0, 1'b0, 1'b1);
    send_txn(OP_FORWARD, 8'd7, 8'h03, 32'h0, 32'h0, 1'b1, 1'b0);
    // Reported never-logged value on a logged code passes after two reports.
    send_txn(OP_REPORT, 8'd7, SEV_NEVER, 32'h11, 32'h22, 1'b0, 1'b0);
    send_txn(OP_REPORT, 8'd7, SEV_NEVER, 32'h33, 32'h44, 1'b0, 1'b0);
    // Return to the committed level clears the candidate, so the count restarts.
    send_txn(OP_REPORT, 8'd7, 8'h03, 32'h55, 32'h66, 1'b0, 1'b0);
    send_txn(OP_REPORT, 8'd7, SEV_NEVER, 32'h77, 32'h88, 1'b0, 1'b0);
    send_txn(OP_REPORT, 8'd128, 8'h7F, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0);

    // Random part over the idle phases: none, sender idle, receiver stalling,
    // both lightly.
    send_idle_pct = 0;  recv_stall_pct = 0;
    random_traffic(PHASE_ITEMS);
    send_idle_pct = 87; recv_stall_pct = 0;
    random_traffic(PHASE_ITEMS);
    send_idle_pct = 0;  recv_stall_pct = 87;
    random_traffic(PHASE_ITEMS);
    send_idle_pct = 11; recv_stall_pct = 11;
    random_traffic(PHASE_ITEMS);
    in_valid <= 1'b0;

    // Drain: outstanding is read at the falling edge, after the checker updated it.
    do @(negedge clk); while (outstanding != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/pcsdf_pkg.sv
hw/rtl/pcsdf_table.sv
hw/rtl/pcsdf_update.sv
hw/rtl/per_code_severity_debounce_filter_top.sv
hw/rtl/pcsdf_checker.sv
tb/debounce_filter_checker.sv
tb/per_code_severity_debounce_filter_top_test.sv
